### sv/psieve_pkg.sv
// ----------------------------------------------------------------------------
// psieve_pkg
// Shared constants, word types and the memory request bundle of the
// prime sieve table.
// ----------------------------------------------------------------------------
package psieve_pkg;

    // Table geometry
    localparam int TABLE_SIZE = 65536;
    localparam int ADDR_W     = $clog2(TABLE_SIZE);
    localparam int LIM_W      = ADDR_W + 1;
    localparam int K_W        = LIM_W + 1;
    localparam int BASE_W     = ADDR_W / 2 + 2;

    // Fixed field widths
    localparam int VAL_W = 16;
    localparam int CFG_W = 17;

    // Sieve constants
    localparam int FIRST_PRIME = 2;
    localparam int LIMIT_FLOOR = 23;

    // Command codes
    localparam logic CMD_BUILD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Input word
    typedef struct packed {
        logic             command;
        logic [VAL_W-1:0] query_value;
    } t_in;

    // Result word
    typedef struct packed {
        logic is_prime;
        logic in_range;
        logic build_done;
    } t_out;

    // Table memory request from the sequencer
    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic              wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

### sv/psieve_ram.sv
// ----------------------------------------------------------------------------
// psieve_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered. Read data holds while no read is issued.
// ----------------------------------------------------------------------------
module psieve_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/psieve_ctrl.sv
// ----------------------------------------------------------------------------
// psieve_ctrl
// Sequencer around the table memory: fill sweep, sieve over prime bases,
// single-bit queries, and the result word handed to the output register.
// ----------------------------------------------------------------------------
module psieve_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  psieve_pkg::t_in              i_in,
    input  logic [psieve_pkg::LIM_W-1:0] i_lim,
    output psieve_pkg::t_mem_req         o_mem,
    input  logic                         i_rd_data,
    output logic                         o_res_valid,
    output psieve_pkg::t_out             o_res,
    input  logic                         i_res_ready
);
    import psieve_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_FILL     = 7'b0000010,
        S_BASE_RD  = 7'b0000100,
        S_BASE_CHK = 7'b0001000,
        S_MARK     = 7'b0010000,
        S_QUERY    = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state              r_state, n_state;
    logic [K_W-1:0]      r_k, n_k;
    logic [BASE_W-1:0]   r_base, n_base;
    logic [K_W-1:0]      r_sq, n_sq;
    logic                r_built, n_built;
    logic                r_inr, n_inr;
    logic                r_ok, n_ok;
    logic [K_W-1:0]      k_step;
    logic [K_W-1:0]      lim_k;

    assign o_in_ready = (r_state == S_IDLE);
    assign lim_k      = K_W'(i_lim);
    assign k_step     = r_k + K_W'(r_base);

    // Next state, memory requests and result word
    always_comb begin
        n_state     = r_state;
        n_k         = r_k;
        n_base      = r_base;
        n_sq        = r_sq;
        n_built     = r_built;
        n_inr       = r_inr;
        n_ok        = r_ok;
        o_mem       = '0;
        o_res_valid = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in.command == CMD_BUILD) begin
                        n_k     = '0;
                        n_state = S_FILL;
                    end else begin
                        o_mem.re    = 1'b1;
                        o_mem.raddr = ADDR_W'(i_in.query_value);
                        n_inr       = (32'(i_in.query_value) < 32'(i_lim));
                        n_ok        = r_built &&
                                      (32'(i_in.query_value) >= 32'(FIRST_PRIME));
                        n_state     = S_QUERY;
                    end
                end
            end
            S_FILL: begin
                // Rewrite every entry: prime candidates are 2 to limit-1
                o_mem.we    = 1'b1;
                o_mem.waddr = r_k[ADDR_W-1:0];
                o_mem.wdata = (r_k >= K_W'(FIRST_PRIME)) && (r_k < lim_k);
                n_k         = r_k + K_W'(1);
                if (&r_k[ADDR_W-1:0]) begin
                    n_base  = BASE_W'(FIRST_PRIME);
                    n_sq    = K_W'(FIRST_PRIME * FIRST_PRIME);
                    n_state = S_BASE_RD;
                end
            end
            S_BASE_RD: begin
                // Stop once the square of the base reaches the limit
                if (r_sq >= lim_k) begin
                    n_built = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_mem.re    = 1'b1;
                    o_mem.raddr = ADDR_W'(r_base);
                    n_state     = S_BASE_CHK;
                end
            end
            S_BASE_CHK: begin
                // Composite bases are already covered by their prime factors
                if (i_rd_data) begin
                    n_k     = r_sq;
                    n_state = S_MARK;
                end else begin
                    n_base  = r_base + BASE_W'(1);
                    n_sq    = r_sq + K_W'({r_base, 1'b1});
                    n_state = S_BASE_RD;
                end
            end
            S_MARK: begin
                // Clear one multiple per cycle
                o_mem.we    = 1'b1;
                o_mem.waddr = r_k[ADDR_W-1:0];
                o_mem.wdata = 1'b0;
                n_k         = k_step;
                if (k_step >= lim_k) begin
                    n_base  = r_base + BASE_W'(1);
                    n_sq    = r_sq + K_W'({r_base, 1'b1});
                    n_state = S_BASE_RD;
                end
            end
            S_QUERY: begin
                // Read data holds until the result word is taken
                o_res_valid       = 1'b1;
                o_res.is_prime    = i_rd_data & r_ok & r_inr;
                o_res.in_range    = r_inr;
                o_res.build_done  = 1'b0;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_DONE: begin
                o_res_valid      = 1'b1;
                o_res.build_done = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_built <= 1'b0;
        end else begin
            r_state <= n_state;
            r_built <= n_built;
        end
    end

    // Sweep and query registers
    always_ff @(posedge i_clk) begin
        r_k    <= n_k;
        r_base <= n_base;
        r_sq   <= n_sq;
        r_inr  <= n_inr;
        r_ok   <= n_ok;
    end

endmodule

### sv/prime_sieve_table.sv
// ----------------------------------------------------------------------------
// prime_sieve_table
// A query word is taken only while the sequencer is idle; the table read and
// the result word are registered, and no new word is taken until the result
// is handed off. A build fills all TABLE_SIZE entries, reads each base below
// the square root of the limit, and clears each multiple of each prime base.
// Reset: limit returns to 65536 and the table reads as not built (all queries
// answer not prime); the memory itself is not swept.
// ----------------------------------------------------------------------------
module prime_sieve_table (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  psieve_pkg::t_in              i_in_data,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output psieve_pkg::t_out             o_out_data,
    input  logic                         i_cfg_we,
    input  logic [psieve_pkg::CFG_W-1:0] i_cfg_data
);
    import psieve_pkg::*;

    logic [CFG_W-1:0] r_limit;
    logic [LIM_W-1:0] eff_lim;
    t_mem_req         mem_req;
    logic             rd_data;
    logic             res_valid;
    t_out             res;
    logic             res_ready;
    logic             r_out_valid;
    t_out             r_out;

    // Limit register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= CFG_W'(TABLE_SIZE);
        end else if (i_cfg_we) begin
            r_limit <= i_cfg_data;
        end
    end

    // Saturate the limit into the usable range
    always_comb begin
        if (32'(r_limit) < 32'(LIMIT_FLOOR)) begin
            eff_lim = LIM_W'(LIMIT_FLOOR);
        end else if (32'(r_limit) > 32'(TABLE_SIZE)) begin
            eff_lim = LIM_W'(TABLE_SIZE);
        end else begin
            eff_lim = LIM_W'(r_limit);
        end
    end

    psieve_ram #(
        .WIDTH (1),
        .DEPTH (TABLE_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

    psieve_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in_data),
        .i_lim       (eff_lim),
        .o_mem       (mem_req),
        .i_rd_data   (rd_data),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_ready (res_ready)
    );

    // Output word register
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

### sim/prime_sieve_table_tb.sv
// ----------------------------------------------------------------------------
// prime_sieve_table_tb
// Self-checking bench for the prime sieve table. Build and query words are
// pushed in bursts against a receiver that stalls on its own pattern, and
// every result word is checked against an in-bench sieve that tracks the
// limit register and the table as last built.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module prime_sieve_table_tb;

    import psieve_pkg::*;

    localparam int LONG_HOLD  = 320;
    localparam int SEG_COUNT  = 4;
    localparam int SEG_WORDS  = 132;
    localparam int PRINT_CAP  = 200;

    // Expected-result store and sieve predictor
    class sieve_scoreboard;
        bit               prime_tab [TABLE_SIZE];
        bit               built;
        logic [CFG_W-1:0] limit_reg;
        t_out             answer_q [$];
        int               errors;

        function new();
            built     = 1'b0;
            limit_reg = CFG_W'(TABLE_SIZE);
            errors    = 0;
        endfunction

        task report(input string msg);
            errors++;
            if (errors <= PRINT_CAP) begin
                $display("[%0t] MISMATCH: %s", $realtime, msg);
            end
        endtask

        function void set_limit(input logic [CFG_W-1:0] v);
            limit_reg = v;
        endfunction

        // Saturate the register into the supported window
        function int eff_limit();
            int lim;
            lim = int'(limit_reg);
            if (lim < LIMIT_FLOOR) lim = LIMIT_FLOOR;
            if (lim > TABLE_SIZE) lim = TABLE_SIZE;
            return lim;
        endfunction

        // Sieve of Eratosthenes over the whole table
        function void rebuild();
            int lim;
            lim = eff_limit();
            for (int k = 0; k < TABLE_SIZE; k++) begin
                prime_tab[k] = (k >= FIRST_PRIME) && (k < lim);
            end
            for (int b = FIRST_PRIME; b * b < lim; b++) begin
                for (int k = b * b; k < lim; k += b) prime_tab[k] = 1'b0;
            end
            built = 1'b1;
        endfunction

        function void note_word(input t_in w);
            t_out ans;
            int   val;
            ans = '0;
            if (w.command == CMD_BUILD) begin
                rebuild();
                ans.build_done = 1'b1;
            end else begin
                val = int'(w.query_value);
                if (val < eff_limit()) begin
                    ans.in_range = 1'b1;
                    if (built && val >= FIRST_PRIME) ans.is_prime = prime_tab[val];
                end
            end
            answer_q.push_back(ans);
        endfunction

        task check_word(input t_out got);
            t_out exp_w;
            if (answer_q.size() == 0) begin
                report($sformatf("result word with none expected: %b", got));
            end else begin
                exp_w = answer_q.pop_front();
                if (got.is_prime !== exp_w.is_prime || got.in_range !== exp_w.in_range ||
                    got.build_done !== exp_w.build_done) begin
                    report($sformatf("is_prime %b/%b in_range %b/%b build_done %b/%b (got/exp)",
                        got.is_prime, exp_w.is_prime, got.in_range, exp_w.in_range,
                        got.build_done, exp_w.build_done));
                end
            end
        endtask

        function int outstanding();
            return answer_q.size();
        endfunction
    endclass

    logic             clk;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_ready;
    t_in              in_data   = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    t_out             out_data;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_data  = '0;

    sieve_scoreboard sb = new();

    int hold_asked  = 0;
    int hold_served = 0;
    int burst_left  = 0;

    prime_sieve_table dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    // Clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Note accepted words and check results on the same edge samples
    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) sb.note_word(in_data);
            if (out_valid && out_ready) sb.check_word(out_data);
        end
    end

    // Receiver stall pattern, with a long hold-off on request
    initial begin : rx_pattern
        int mode;
        int span;
        mode = 0;
        span = 0;
        forever begin
            @(posedge clk);
            if (hold_asked != hold_served) begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                hold_served++;
            end
            if (span == 0) begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 150);
            end
            span--;
            case (mode)
                0: begin
                    out_ready <= 1'b1;
                end
                1: begin
                    out_ready <= ($urandom_range(0, 9) < 6);
                end
                default: begin
                    out_ready <= ((span % 4) == 0);
                end
            endcase
        end
    end

    // Offer one word and hold it until accepted
    task automatic send_word(input t_in w);
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Send a word as part of a burst, with random gaps between bursts
    task automatic send_paced(input t_in w);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        send_word(w);
    endtask

    task automatic send_query(input logic [VAL_W-1:0] v);
        t_in w;
        w.command     = CMD_QUERY;
        w.query_value = v;
        send_paced(w);
    endtask

    task automatic send_build();
        t_in w;
        w.command     = CMD_BUILD;
        w.query_value = VAL_W'($urandom());
        send_paced(w);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        cfg_data <= v;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        sb.set_limit(v);
    endtask

    // Pick a query value, weighted towards the live range and its edges
    function automatic logic [VAL_W-1:0] pick_value(input int lim);
        int top;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                return VAL_W'($urandom_range(0, lim - 1));
            end
            5: begin
                case ($urandom_range(0, 5))
                    0: return VAL_W'(0);
                    1: return VAL_W'(1);
                    2: return VAL_W'(FIRST_PRIME);
                    3: return VAL_W'(lim - 1);
                    4: return VAL_W'((lim < TABLE_SIZE) ? lim : lim - 1);
                    default: return '1;
                endcase
            end
            6, 7: begin
                return VAL_W'($urandom());
            end
            default: begin
                top = (lim + 50 > TABLE_SIZE - 1) ? TABLE_SIZE - 1 : lim + 50;
                return VAL_W'($urandom_range(0, top));
            end
        endcase
    endfunction

    // Main sequence
    initial begin : main_seq
        logic [CFG_W-1:0] lim_v;
        int               build_at;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Queries before any build, then a full-size build at the reset limit
        send_query(VAL_W'(0));
        send_query(VAL_W'(2));
        send_query('1);
        send_query(VAL_W'(7));
        send_build();
        send_query(VAL_W'(0));
        send_query(VAL_W'(1));
        send_query(VAL_W'(2));
        send_query(VAL_W'(3));
        send_query(VAL_W'(4));
        send_query(VAL_W'(65521));
        send_query('1);
        send_query(VAL_W'(65534));
        drain();

        // Limit below the floor: range shrinks on the old table, then rebuild
        write_limit('0);
        send_query(VAL_W'(22));
        send_query(VAL_W'(23));
        send_query(VAL_W'(19));
        send_build();
        send_query(VAL_W'(22));
        send_query(VAL_W'(23));
        send_query(VAL_W'(17));
        send_query(VAL_W'(21));
        drain();

        // Limit above the table: range widens, table still the small one
        write_limit('1);
        send_query(VAL_W'(23));
        send_query(VAL_W'(29));
        send_query(VAL_W'(65521));
        send_query(VAL_W'(40000));
        drain();

        // Random segments, each with its own limit setting
        for (int seg = 0; seg < SEG_COUNT; seg++) begin
            case (seg)
                0: lim_v = CFG_W'($urandom_range(LIMIT_FLOOR, 1500));
                1: lim_v = CFG_W'($urandom_range(0, LIMIT_FLOOR));
                2: lim_v = CFG_W'($urandom());
                default: lim_v = CFG_W'($urandom_range(1500, 8000));
            endcase
            write_limit(lim_v);
            // Rebuild first in segment 0, at a random point in the others, except in the wide-limit segment
            build_at = (seg == 2) ? -1 : ((seg == 0) ? 0 : $urandom_range(0, SEG_WORDS - 1));
            for (int n = 0; n < SEG_WORDS; n++) begin
                // Long receiver hold-off while queries keep coming
                if (seg == 0 && n == SEG_WORDS / 2) hold_asked++;
                if (n == build_at) send_build();
                else send_query(pick_value(sb.eff_limit()));
            end
            drain();
        end

        repeat (20) @(posedge clk);
        if (sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### filelist.f
sv/psieve_pkg.sv
sv/psieve_ram.sv
sv/psieve_ctrl.sv
sv/prime_sieve_table.sv
sim/prime_sieve_table_tb.sv
